/* src/assert_macros.svh */
// Assertion macros shared by the qualifier RTL.
// Included by the files that carry concurrent checks; no other dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define RCPQ_ASSERT_IMPLY(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled during reset.
`define RCPQ_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* src/rcpq_pkg.sv */
// Package for the RC PWM input qualifier: control states, link codes,
// register indexes, fixed constants and the divider request/response structs.
`default_nettype none

package rcpq_pkg;

	localparam int DIV_W  = 26;
	localparam int DSR_W  = 17;

	localparam logic [1:0] LINK_NC       = 2'd0;
	localparam logic [1:0] LINK_UNSTABLE = 2'd1;
	localparam logic [1:0] LINK_STABLE   = 2'd2;

	localparam logic [2:0] REG_PULSE_MIN   = 3'd0;
	localparam logic [2:0] REG_PULSE_MAX   = 3'd1;
	localparam logic [2:0] REG_NEUTRAL     = 3'd2;
	localparam logic [2:0] REG_NO_SIGNAL   = 3'd3;
	localparam logic [2:0] REG_AUTO_ZERO   = 3'd4;
	localparam logic [2:0] REG_AUTO_MINMAX = 3'd5;
	localparam logic [2:0] REG_FAILSAFE    = 3'd6;
	localparam logic [2:0] REG_CAL_TIME    = 3'd7;

	localparam logic [15:0] OUT_LOW  = 16'd1000;
	localparam logic [15:0] OUT_MID  = 16'd1500;
	localparam logic [8:0]  SEG_SPAN = 9'd500;
	localparam logic [6:0]  PCT_DEN  = 7'd100;
	localparam logic [19:0] FREQ_NUM = 20'd1000000;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_FREQ,
		ST_ZDIV,
		ST_LDIV,
		ST_UDIV,
		ST_APPLY,
		ST_MAP,
		ST_OUT
	} ctl_state_t;

	typedef struct packed {
		logic             start;
		logic [DIV_W-1:0] dividend;
		logic [DSR_W-1:0] divisor;
	} div_req_t;

	typedef struct packed {
		logic             busy;
		logic             done;
		logic [DIV_W-1:0] quotient;
	} div_rsp_t;

endpackage

`default_nettype wire

/* src/rcpq_div.sv */
// Bit-serial restoring divider: one quotient bit per clock.
// Depends on rcpq_pkg for widths and the request/response structs.
`default_nettype none

module rcpq_div (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire rcpq_pkg::div_req_t req,
	output rcpq_pkg::div_rsp_t     rsp
);
	import rcpq_pkg::*;

	localparam int CNT_W = $clog2(DIV_W + 1);

	logic [DIV_W-1:0] dvd_q;
	logic [DSR_W-1:0] dsr_q;
	logic [DSR_W-1:0] rem_q;
	logic [CNT_W-1:0] cnt_q;
	logic             busy_q;
	logic             done_q;

	logic [DSR_W:0]   trial;
	logic [DSR_W:0]   diff;
	logic             ge;

	always_comb begin
		trial = {rem_q, dvd_q[DIV_W-1]};
		diff  = trial - {1'b0, dsr_q};
		ge    = trial >= {1'b0, dsr_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start && !busy_q) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(DIV_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - CNT_W'(1);
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start && !busy_q) begin
			dvd_q <= req.dividend;
			dsr_q <= req.divisor;
			rem_q <= '0;
		end else if (busy_q) begin
			rem_q <= ge ? diff[DSR_W-1:0] : trial[DSR_W-1:0];
			dvd_q <= {dvd_q[DIV_W-2:0], ge};
		end
	end

	assign rsp.busy     = busy_q;
	assign rsp.done     = done_q;
	assign rsp.quotient = dvd_q;

endmodule

`default_nettype wire

/* src/rc_pwm_input_qualifier_core.sv */
// Top level of the RC PWM input qualifier: link state machine, learning logic,
// sequencer and output register. Depends on rcpq_pkg, rcpq_div, assert_macros.svh.
`default_nettype none

// One pulse transaction is taken at a time. After acceptance the bit-serial
// divider runs five times (frequency, neutral tolerance, lower and upper
// calibration tolerance, segment map), each run launching it, shifting out the
// 26-bit quotient and ending with done; an update state between the fourth and
// fifth run and an output state follow. The input is taken again once the result
// sits in the output register, even while it waits.
module rc_pwm_input_qualifier_core #(
	parameter int STABLE_COUNT   = 10,
	parameter int PERIOD_LOW_US  = 2500,
	parameter int PERIOD_HIGH_US = 25000,
	parameter int ZERO_TOL_PCT   = 10,
	parameter int MINMAX_MID_US  = 400,
	parameter int MINMAX_TOL_PCT = 10
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               cfg_we,
	input  wire logic [2:0]         cfg_index,
	input  wire logic [31:0]        cfg_data,
	input  wire logic               in_valid,
	output logic                    in_stall,
	input  wire logic [31:0]        timestamp_us,
	input  wire logic [15:0]        high_time_us,
	output logic                    out_valid,
	input  wire logic               out_stall,
	output logic [1:0]              link_state,
	output logic [15:0]             period_us,
	output logic [19:0]             frequency_hz,
	output logic signed [16:0]      raw_pulse,
	output logic signed [16:0]      scaled_pulse,
	output logic [15:0]             learned_neutral_us
);
	import rcpq_pkg::*;

	localparam logic [6:0]  ZTOL = 7'(ZERO_TOL_PCT);
	localparam logic [6:0]  MTOL = 7'(MINMAX_TOL_PCT);
	localparam logic [16:0] MMID = 17'(MINMAX_MID_US);

	// configuration
	logic [15:0] no_sig_q;
	logic        zero_en_q;
	logic        failsafe_q;
	logic [31:0] cal_time_q;

	// qualifier state
	logic [31:0] last_time_q;
	logic [15:0] period_now_q;
	logic [15:0] period_before_q;
	logic [1:0]  link_q;
	logic [7:0]  cnt_q;
	logic [31:0] stable_since_q;
	logic [15:0] seen_min_q;
	logic [15:0] seen_max_q;
	logic [15:0] neutral_q;
	logic [15:0] min_q;
	logic [15:0] max_q;
	logic        calib_q;

	// per-transaction working registers
	logic [31:0] now_q;
	logic [15:0] high_q;
	logic        do_zero_q;
	logic        do_cal_q;
	logic [19:0] freq_q;
	logic [15:0] zd_q;
	logic [9:0]  lq_q;
	logic [9:0]  uq_q;
	logic        map_neg_q;
	logic        map_low_q;
	logic        map_eq_q;
	logic        launched_q;

	ctl_state_t state_q, state_nxt;
	div_req_t   div_req;
	div_rsp_t   div_rsp;
	logic       accept;
	logic       is_div_state;
	logic       out_load;

	rcpq_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	assign accept   = in_valid && !in_stall;
	assign in_stall = (state_q != ST_IDLE);

	// link update, evaluated on the incoming transaction
	logic [31:0] gap;
	logic [15:0] period_new;
	logic        sig_lost;
	logic        oor;
	logic [18:0] p5;
	logic [18:0] b4;
	logic [18:0] b6;
	logic [1:0]  link_new;
	logic [7:0]  cnt_new;
	logic        enter_stable;
	logic        cal_step;

	always_comb begin
		gap        = timestamp_us - last_time_q;
		period_new = (gap > 32'h0000_FFFF) ? 16'hFFFF : gap[15:0];
		sig_lost   = {1'b0, gap} > {16'b0, no_sig_q, 1'b0};
		p5         = 19'(period_new) * 19'd5;
		b4         = 19'(period_now_q) * 19'd4;
		b6         = 19'(period_now_q) * 19'd6;
		oor        = (period_new > 16'(PERIOD_HIGH_US)) || (period_new < 16'(PERIOD_LOW_US))
		             || (p5 <= b4) || (p5 >= b6);
		link_new     = link_q;
		cnt_new      = cnt_q;
		enter_stable = 1'b0;
		cal_step     = 1'b0;
		unique case (link_q)
			LINK_UNSTABLE: begin
				if (sig_lost) begin
					link_new = LINK_NC;
				end else if (oor) begin
					cnt_new = '0;
				end else if (cnt_q == 8'(STABLE_COUNT)) begin
					cnt_new      = '0;
					link_new     = LINK_STABLE;
					enter_stable = 1'b1;
				end else begin
					cnt_new = cnt_q + 8'd1;
				end
			end
			LINK_STABLE: begin
				if (sig_lost) begin
					link_new = LINK_NC;
				end else if (oor) begin
					link_new = LINK_UNSTABLE;
					cnt_new  = '0;
				end else begin
					cal_step = calib_q;
				end
			end
			default: begin
				link_new = LINK_UNSTABLE;
				cnt_new  = '0;
			end
		endcase
	end

	// segment map operands, taken from the updated calibration registers
	logic [15:0] seg_a;
	logic [15:0] seg_b;
	logic [17:0] seg_num;
	logic [17:0] seg_den;
	logic [16:0] num_mag;
	logic [16:0] den_mag;
	logic [DIV_W-1:0] map_prod;
	logic        map_low;

	always_comb begin
		map_low  = high_q <= neutral_q;
		seg_a    = map_low ? min_q : neutral_q;
		seg_b    = map_low ? neutral_q : max_q;
		seg_num  = {2'b0, high_q} - {2'b0, seg_a};
		seg_den  = {2'b0, seg_b} - {2'b0, seg_a};
		num_mag  = seg_num[17] ? 17'(-seg_num) : seg_num[16:0];
		den_mag  = seg_den[17] ? 17'(-seg_den) : seg_den[16:0];
		map_prod = DIV_W'(num_mag) * DIV_W'(SEG_SPAN);
	end

	// tolerance operands
	logic [17:0] lmid;
	logic [16:0] lmid_mag;
	logic [16:0] umid;

	always_comb begin
		lmid     = {2'b0, neutral_q} - {1'b0, MMID};
		lmid_mag = lmid[17] ? 17'(-lmid) : lmid[16:0];
		umid     = {1'b0, neutral_q} + MMID;
	end

	// sequencer
	always_comb begin
		is_div_state = (state_q == ST_FREQ) || (state_q == ST_ZDIV) || (state_q == ST_LDIV)
		               || (state_q == ST_UDIV) || (state_q == ST_MAP);
		out_load     = (state_q == ST_OUT) && (!out_valid || !out_stall);
	end

	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			ST_IDLE:  if (accept) state_nxt = ST_FREQ;
			ST_FREQ:  if (div_rsp.done) state_nxt = ST_ZDIV;
			ST_ZDIV:  if (div_rsp.done) state_nxt = ST_LDIV;
			ST_LDIV:  if (div_rsp.done) state_nxt = ST_UDIV;
			ST_UDIV:  if (div_rsp.done) state_nxt = ST_APPLY;
			ST_APPLY: state_nxt = ST_MAP;
			ST_MAP:   if (div_rsp.done) state_nxt = ST_OUT;
			ST_OUT:   if (out_load) state_nxt = ST_IDLE;
			default:  state_nxt = ST_IDLE;
		endcase
	end

	always_comb begin
		div_req.start    = is_div_state && !launched_q;
		div_req.dividend = '0;
		div_req.divisor  = DSR_W'(PCT_DEN);
		unique case (state_q)
			ST_FREQ: begin
				div_req.dividend = DIV_W'(FREQ_NUM);
				div_req.divisor  = {1'b0, period_now_q};
			end
			ST_ZDIV: div_req.dividend = DIV_W'(neutral_q) * DIV_W'(ZTOL);
			ST_LDIV: div_req.dividend = DIV_W'(lmid_mag);
			ST_UDIV: div_req.dividend = DIV_W'(umid);
			ST_MAP: begin
				div_req.dividend = map_prod;
				div_req.divisor  = den_mag;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			launched_q <= 1'b0;
		end else begin
			state_q <= state_nxt;
			if (div_rsp.done) launched_q <= 1'b0;
			else if (div_req.start) launched_q <= 1'b1;
		end
	end

	// calibration window and limits
	logic [31:0] elapsed;
	logic signed [18:0] lmid_s;
	logic signed [18:0] umid_s;
	logic signed [18:0] dl;
	logic signed [18:0] du;
	logic signed [18:0] smin_s;
	logic signed [18:0] smax_s;
	logic [16:0] z_lo;
	logic [16:0] z_hi;

	always_comb begin
		elapsed = now_q - stable_since_q;
		lmid_s  = 19'(signed'(lmid));
		umid_s  = signed'({2'b0, umid});
		dl      = (lmid[17] ? -signed'({9'b0, lq_q}) : signed'({9'b0, lq_q}))
		          * signed'({12'b0, MTOL});
		du      = signed'({9'b0, uq_q}) * signed'({12'b0, MTOL});
		smin_s  = signed'({3'b0, seen_min_q});
		smax_s  = signed'({3'b0, seen_max_q});
		z_lo    = {1'b0, neutral_q} - {1'b0, zd_q};
		z_hi    = {1'b0, neutral_q} + {1'b0, zd_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			no_sig_q        <= 16'd40000;
			zero_en_q       <= 1'b0;
			failsafe_q      <= 1'b0;
			cal_time_q      <= 32'd10000000;
			last_time_q     <= '0;
			period_now_q    <= '0;
			period_before_q <= '0;
			link_q          <= LINK_NC;
			cnt_q           <= '0;
			stable_since_q  <= '0;
			seen_min_q      <= '0;
			seen_max_q      <= '0;
			neutral_q       <= OUT_MID;
			min_q           <= OUT_LOW;
			max_q           <= 16'd2000;
			calib_q         <= 1'b0;
			do_zero_q       <= 1'b0;
			do_cal_q        <= 1'b0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					REG_PULSE_MIN:   min_q       <= cfg_data[15:0];
					REG_PULSE_MAX:   max_q       <= cfg_data[15:0];
					REG_NEUTRAL:     neutral_q   <= cfg_data[15:0];
					REG_NO_SIGNAL:   no_sig_q    <= cfg_data[15:0];
					REG_AUTO_ZERO:   zero_en_q   <= cfg_data[0];
					REG_AUTO_MINMAX: calib_q     <= cfg_data[0];
					REG_FAILSAFE:    failsafe_q  <= cfg_data[0];
					REG_CAL_TIME:    cal_time_q  <= cfg_data;
					default: ;
				endcase
			end
			if (accept) begin
				period_before_q <= period_now_q;
				period_now_q    <= period_new;
				last_time_q     <= timestamp_us;
				link_q          <= link_new;
				cnt_q           <= cnt_new;
				if (enter_stable) stable_since_q <= timestamp_us;
				do_zero_q <= enter_stable && zero_en_q;
				do_cal_q  <= cal_step;
			end
			if (state_q == ST_APPLY) begin
				if (do_zero_q && ({1'b0, high_q} > z_lo) && ({1'b0, high_q} < z_hi))
					neutral_q <= high_q;
				if (do_cal_q) begin
					if (elapsed >= cal_time_q) begin
						if (smin_s > lmid_s - dl && smin_s < lmid_s + dl) min_q <= seen_min_q;
						if (smax_s > umid_s - du && smax_s < umid_s + du) max_q <= seen_max_q;
						calib_q <= 1'b0;
					end else begin
						if (seen_min_q == 16'd0 || high_q < seen_min_q) seen_min_q <= high_q;
						if (high_q > seen_max_q) seen_max_q <= high_q;
					end
				end
			end
		end
	end

	// payload capture
	always_ff @(posedge clk) begin
		if (accept) begin
			now_q  <= timestamp_us;
			high_q <= high_time_us;
		end
		if (div_rsp.done) begin
			unique case (state_q)
				ST_FREQ: freq_q <= (period_now_q == 16'd0) ? 20'd0 : div_rsp.quotient[19:0];
				ST_ZDIV: zd_q   <= div_rsp.quotient[15:0];
				ST_LDIV: lq_q   <= div_rsp.quotient[9:0];
				ST_UDIV: uq_q   <= div_rsp.quotient[9:0];
				default: ;
			endcase
		end
		if (state_q == ST_MAP && div_req.start) begin
			map_neg_q <= seg_num[17] ^ seg_den[17];
			map_low_q <= map_low;
			map_eq_q  <= (seg_a == seg_b);
		end
	end

	// result assembly
	logic signed [27:0] map_val;
	logic [15:0]        map_sat;
	logic [16:0]        fail_val;

	always_comb begin
		map_val = signed'({12'b0, map_low_q ? OUT_LOW : OUT_MID})
		          + (map_neg_q ? -signed'({2'b0, div_rsp.quotient})
		                       :  signed'({2'b0, div_rsp.quotient}));
		priority if (map_eq_q)              map_sat = OUT_MID;
		else if (map_val < 28'sd0)          map_sat = 16'd0;
		else if (map_val > 28'sd65535)      map_sat = 16'hFFFF;
		else                                map_sat = map_val[15:0];
		fail_val = failsafe_q ? {1'b0, neutral_q} : 17'h1FFFF;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (out_load) begin
			out_valid <= 1'b1;
		end else if (!out_stall) begin
			out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			link_state         <= link_q;
			period_us          <= period_now_q;
			frequency_hz       <= freq_q;
			learned_neutral_us <= neutral_q;
			if (link_q == LINK_STABLE) begin
				raw_pulse    <= signed'({1'b0, high_q});
				scaled_pulse <= signed'({1'b0, map_sat});
			end else begin
				raw_pulse    <= signed'(fail_val);
				scaled_pulse <= signed'(fail_val);
			end
		end
	end

`include "assert_macros.svh"

	`RCPQ_ASSERT_NEXT(a_accept_starts, clk, arst_n, accept, state_q == ST_FREQ, "no FREQ after accept")
	`RCPQ_ASSERT_IMPLY(a_div_done_state, clk, arst_n, div_rsp.done, is_div_state, "stray done")
	`RCPQ_ASSERT_IMPLY(a_no_start_busy, clk, arst_n, div_req.start, !div_rsp.busy, "start while busy")

endmodule

`default_nettype wire

/* bench/rc_pwm_input_qualifier_core_tb.sv */
// Self-checking bench for rc_pwm_input_qualifier_core: a scoreboard class predicts
// every result from the accepted pulses and register writes. Depends on rcpq_pkg.
`default_nettype none

module rc_pwm_input_qualifier_core_tb;
	timeunit 1ns;
	timeprecision 1ps;
	import rcpq_pkg::*;

	localparam int  STABLE_PULSES = 10;
	localparam int  PER_LOW       = 2500;
	localparam int  PER_HIGH      = 25000;
	localparam int  ZERO_TOL      = 10;
	localparam int  MM_MID        = 400;
	localparam int  MM_TOL        = 10;
	localparam int  MAP_HIGH      = 2000;
	localparam int  DRAIN_CYCLES  = 400;
	localparam longint CYCLE_LIMIT = 8000000;

	typedef struct packed {
		logic [1:0]  link;
		logic [15:0] period;
		logic [19:0] freq;
		logic [16:0] raw;
		logic [16:0] scaled;
		logic [15:0] neutral;
	} pulse_result_t;

	class qualifier_scoreboard;
		bit [15:0] reg_min, reg_max, reg_neutral, reg_no_signal;
		bit        zero_en, auto_minmax, failsafe;
		bit [31:0] cal_time;
		bit [31:0] last_ts, stable_since;
		bit [15:0] per_now, per_prev, seen_min, seen_max;
		bit [15:0] neutral_used, min_used, max_used;
		bit [1:0]  link;
		bit [7:0]  stable_cnt;
		bit        calibrating;
		pulse_result_t expected_q[$];
		int errors, pulses, checked, stable_hits;

		function new();
			reg_min = 1000; reg_max = 2000; reg_neutral = 1500; reg_no_signal = 40000;
			zero_en = 0; auto_minmax = 0; failsafe = 0; cal_time = 10000000;
			last_ts = 0; stable_since = 0; per_now = 0; per_prev = 0;
			seen_min = 0; seen_max = 0; link = LINK_NC; stable_cnt = 0;
			neutral_used = 1500; min_used = 1000; max_used = 2000; calibrating = 0;
			errors = 0; pulses = 0; checked = 0; stable_hits = 0;
		endfunction

		function void write_reg(logic [2:0] idx, bit [31:0] d);
			case (idx)
				REG_PULSE_MIN:   begin reg_min = d[15:0]; min_used = d[15:0]; end
				REG_PULSE_MAX:   begin reg_max = d[15:0]; max_used = d[15:0]; end
				REG_NEUTRAL:     begin reg_neutral = d[15:0]; neutral_used = d[15:0]; end
				REG_NO_SIGNAL:   reg_no_signal = d[15:0];
				REG_AUTO_ZERO:   zero_en = d[0];
				REG_AUTO_MINMAX: begin auto_minmax = d[0]; calibrating = d[0]; end
				REG_FAILSAFE:    failsafe = d[0];
				REG_CAL_TIME:    cal_time = d;
				default: ;
			endcase
		endfunction

		function longint seg_map(longint x, longint a, longint b, longint lo, longint hi);
			if (a == b)
				return OUT_MID;
			return (x - a) * (hi - lo) / (b - a) + lo;
		endfunction

		function void calibrate(bit [31:0] ts, bit [15:0] high);
			longint lmid, umid, dl, du;
			bit [31:0] elapsed;
			lmid = longint'(neutral_used) - MM_MID;
			umid = longint'(neutral_used) + MM_MID;
			dl = MM_TOL * (lmid / 100);
			du = MM_TOL * (umid / 100);
			elapsed = ts - stable_since;
			if (elapsed >= cal_time) begin
				if (longint'(seen_min) > lmid - dl && longint'(seen_min) < lmid + dl)
					min_used = seen_min;
				if (longint'(seen_max) > umid - du && longint'(seen_max) < umid + du)
					max_used = seen_max;
				calibrating = 0;
			end else begin
				if (seen_min == 0 || high < seen_min)
					seen_min = high;
				if (high > seen_max)
					seen_max = high;
			end
		endfunction

		function void note_pulse(bit [31:0] ts, bit [15:0] high);
			bit [31:0] gap;
			bit no_sig, oor;
			int unsigned p, q;
			longint n, d, raw, scaled;
			pulse_result_t r;
			gap = ts - last_ts;
			per_prev = per_now;
			per_now = (gap > 32'hFFFF) ? 16'hFFFF : gap[15:0];
			last_ts = ts;
			p = per_now;
			q = per_prev;
			no_sig = {1'b0, gap} > {16'b0, reg_no_signal, 1'b0};
			oor = p > PER_HIGH || p < PER_LOW || 5 * p <= 4 * q || 5 * p >= 6 * q;
			case (link)
				LINK_UNSTABLE: begin
					if (no_sig)
						link = LINK_NC;
					else if (oor)
						stable_cnt = 0;
					else if (stable_cnt == STABLE_PULSES) begin
						stable_cnt = 0;
						stable_since = ts;
						link = LINK_STABLE;
						if (zero_en) begin
							n = neutral_used;
							d = (ZERO_TOL * n) / 100;
							if (longint'(high) > n - d && longint'(high) < n + d)
								neutral_used = high;
						end
					end else
						stable_cnt++;
				end
				LINK_STABLE: begin
					if (no_sig)
						link = LINK_NC;
					else if (oor) begin
						link = LINK_UNSTABLE;
						stable_cnt = 0;
					end else if (calibrating)
						calibrate(ts, high);
				end
				default: begin
					link = LINK_UNSTABLE;
					stable_cnt = 0;
				end
			endcase
			if (link == LINK_STABLE) begin
				raw = high;
				if (high <= neutral_used)
					scaled = seg_map(high, min_used, neutral_used, OUT_LOW, OUT_MID);
				else
					scaled = seg_map(high, neutral_used, max_used, OUT_MID, MAP_HIGH);
				if (scaled < 0)
					scaled = 0;
				if (scaled > 65535)
					scaled = 65535;
				stable_hits++;
			end else begin
				raw = failsafe ? longint'(neutral_used) : -1;
				scaled = raw;
			end
			r.link = link;
			r.period = per_now;
			r.freq = (per_now != 0) ? 20'(1000000 / p) : 20'd0;
			r.raw = raw[16:0];
			r.scaled = scaled[16:0];
			r.neutral = neutral_used;
			expected_q.push_back(r);
			pulses++;
		endfunction

		function void field_cmp(string name, logic [19:0] exp_v, logic [19:0] act_v);
			if (exp_v !== act_v) begin
				$display("%0t: %s mismatch, expected %0h actual %0h",
					$time, name, exp_v, act_v);
				errors++;
			end
		endfunction

		function void check_result(pulse_result_t act);
			pulse_result_t exp_r;
			if (expected_q.size() == 0) begin
				$display("%0t: result with nothing expected, link %0d period %0d",
					$time, act.link, act.period);
				errors++;
				return;
			end
			exp_r = expected_q.pop_front();
			checked++;
			field_cmp("link_state", exp_r.link, act.link);
			field_cmp("period_us", exp_r.period, act.period);
			field_cmp("frequency_hz", exp_r.freq, act.freq);
			field_cmp("raw_pulse", exp_r.raw, act.raw);
			field_cmp("scaled_pulse", exp_r.scaled, act.scaled);
			field_cmp("learned_neutral_us", exp_r.neutral, act.neutral);
		endfunction
	endclass

	logic        clk, arst_n;
	logic        cfg_we;
	logic [2:0]  cfg_index;
	logic [31:0] cfg_data;
	logic        in_valid, in_stall;
	logic [31:0] timestamp_us;
	logic [15:0] high_time_us;
	logic        out_valid, out_stall;
	logic [1:0]  link_state;
	logic [15:0] period_us;
	logic [19:0] frequency_hz;
	logic signed [16:0] raw_pulse, scaled_pulse;
	logic [15:0] learned_neutral_us;

	rc_pwm_input_qualifier_core dut (
		.clk(clk), .arst_n(arst_n),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.in_valid(in_valid), .in_stall(in_stall),
		.timestamp_us(timestamp_us), .high_time_us(high_time_us),
		.out_valid(out_valid), .out_stall(out_stall),
		.link_state(link_state), .period_us(period_us), .frequency_hz(frequency_hz),
		.raw_pulse(raw_pulse), .scaled_pulse(scaled_pulse),
		.learned_neutral_us(learned_neutral_us)
	);

	qualifier_scoreboard sb = new();
	bit        calm;
	bit [31:0] t_now;
	longint    cycles;
	int        stall_left;

	initial begin
		clk = 0;
		forever #10 clk = ~clk;
	end

	function automatic int gap_len();
		int r;
		r = $urandom_range(99);
		if (calm || r < 60)
			return 0;
		if (r < 95)
			return $urandom_range(1, 4);
		return $urandom_range(20, 300);
	endfunction

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycles);
			$display("CHECK FAILED");
			$finish;
		end
	end

	// result side: check on accept, random backpressure
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_stall <= 1'b0;
			stall_left <= 0;
		end else begin
			if (out_valid && !out_stall)
				sb.check_result({link_state, period_us, frequency_hz, raw_pulse,
					scaled_pulse, learned_neutral_us});
			if (stall_left > 0) begin
				out_stall <= 1'b1;
				stall_left <= stall_left - 1;
			end else begin
				out_stall <= 1'b0;
				if (!calm && $urandom_range(7) == 0)
					stall_left <= gap_len();
			end
		end
	end

	task automatic send_pulse(bit [31:0] ts, bit [15:0] high);
		int g;
		in_valid <= 1'b1;
		timestamp_us <= ts;
		high_time_us <= high;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		sb.note_pulse(ts, high);
		g = gap_len();
		if (g > 0) begin
			in_valid <= 1'b0;
			repeat (g) @(posedge clk);
		end
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		@(posedge clk);
		while (sb.expected_q.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(logic [2:0] idx, bit [31:0] d);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= d;
		@(posedge clk);
		sb.write_reg(idx, d);
	endtask

	task automatic apply_settings(bit [15:0] mn, bit [15:0] mx, bit [15:0] neu,
		bit [15:0] nosig, bit az, bit amm, bit fs, bit [31:0] cal);
		write_reg(REG_PULSE_MIN, {16'b0, mn});
		write_reg(REG_PULSE_MAX, {16'b0, mx});
		write_reg(REG_NEUTRAL, {16'b0, neu});
		write_reg(REG_NO_SIGNAL, {16'b0, nosig});
		write_reg(REG_AUTO_ZERO, {31'b0, az});
		write_reg(REG_AUTO_MINMAX, {31'b0, amm});
		write_reg(REG_FAILSAFE, {31'b0, fs});
		write_reg(REG_CAL_TIME, cal);
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	function automatic bit [15:0] pick_high(int neu);
		int r, v;
		r = $urandom_range(99);
		if (r < 10)
			return 16'($urandom());
		if (r < 35)
			v = neu + $urandom_range(0, 100) - 50;
		else
			v = neu + $urandom_range(0, 1400) - 700;
		if (v < 0)
			v = 0;
		if (v > 65535)
			v = 65535;
		return v[15:0];
	endfunction

	// mostly steady pulse trains with small jitter, some random noise in between
	task automatic run_phase(int n, int neu);
		int sent, per, len, j;
		bit paused;
		sent = 0;
		paused = 0;
		while (sent < n) begin
			if ($urandom_range(99) < 15)
				calm = ~calm;
			if (!paused && sent > n / 2) begin
				drain();
				paused = 1;
			end
			if ($urandom_range(99) < 80) begin
				per = $urandom_range(PER_LOW + 100, PER_HIGH - 1000);
				len = $urandom_range(5, 30);
				for (j = 0; j < len; j++) begin
					t_now += per + $urandom_range(0, per / 12) - per / 25;
					send_pulse(t_now, pick_high(neu));
				end
				sent += len;
			end else begin
				case ($urandom_range(3))
					0: t_now = $urandom();
					1: t_now += $urandom_range(0, 200);
					2: t_now += $urandom_range(60000, 200000);
					default: t_now += $urandom_range(0, 40000);
				endcase
				send_pulse(t_now, 16'($urandom()));
				sent++;
			end
		end
		calm = 0;
		drain();
	endtask

	initial begin
		int i;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		in_valid = 1'b0;
		timestamp_us = '0;
		high_time_us = '0;
		calm = 0;
		cycles = 0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: zero gap, wrap and no signal, then lock and sweep pulse extremes
		send_pulse(32'h0, 16'h0);
		send_pulse(32'hFFFF_FFFF, 16'hFFFF);
		t_now = 32'hFFFF_0000;
		for (i = 0; i < 12; i++) begin
			t_now += 20000;
			send_pulse(t_now, 16'd1500);
		end
		t_now += 20000; send_pulse(t_now, 16'd0);
		t_now += 20000; send_pulse(t_now, 16'd65535);
		t_now += 20000; send_pulse(t_now, 16'd1000);
		t_now += 20000; send_pulse(t_now, 16'd2000);
		t_now += 20000; send_pulse(t_now, 16'd1501);
		t_now += 3000;  send_pulse(t_now, 16'd1500);
		t_now += 90000; send_pulse(t_now, 16'd1500);
		drain();

		apply_settings(1000, 2000, 1500, 40000, 1, 1, 1, 150000);
		run_phase(260, 1500);
		apply_settings(0, 65535, 32768, 65535, 0, 1, 0, 0);
		run_phase(220, 32768);
		apply_settings(65535, 0, 0, 0, 1, 1, 1, 32'hFFFF_FFFF);
		run_phase(60, 0);
		apply_settings(1200, 1800, 1500, 12000, 1, 1, 1, 400000);
		run_phase(320, 1500);
		apply_settings(60000, 65535, 65535, 30000, 1, 0, 0, 10000000);
		run_phase(220, 65000);
		apply_settings(1000, 2000, 1500, 40000, 0, 1, 1, 300000);
		run_phase(400, 1500);

		$display("%0d pulses sent, %0d results compared, %0d of them in locked state",
			sb.pulses, sb.checked, sb.stable_hits);
		$display("covered register extremes, calibration, neutral learning and signal loss");
		if (sb.errors == 0 && sb.expected_q.size() == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end
endmodule

`default_nettype wire
